### rtl/isa_pkg.sv
// Package for the indexed shift array: sizes, operation and status codes,
// controller states and the command and status bundles between the modules.
// Depends on nothing.
`default_nettype none

package isa_pkg;

  localparam int DEPTH    = 64;
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CMP_W    = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_UP,
    S_FIN,
    S_DOWN
  } state_t;

  typedef enum logic [2:0] {
    RD_POS,
    RD_LAST,
    RD_POS_NEXT,
    RD_CUR_DEC,
    RD_CUR_INC
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_COUNT,
    WR_POS,
    WR_CUR_INC,
    WR_CUR_DEC
  } wr_sel_t;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_t;

  typedef struct packed {
    logic                latch;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                wr_en;
    wr_sel_t             wr_sel;
    wd_sel_t             wd_sel;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                finish;
    logic [STATUS_W-1:0] fin_status;
    logic                fin_rdata;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_range;
    logic              full;
    logic              at_pos;
    logic              at_last;
    logic              last_pos;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/isa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`default_nettype none

module isa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/isa_ctrl.sv
// Controller of the indexed shift array: state machine that sequences
// decode, reads and shift passes. Depends on isa_pkg.
`default_nettype none

module isa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire isa_pkg::dp_stat_t  stat,
  output logic                    busy,
  output isa_pkg::dp_cmd_t        cmd
);

  isa_pkg::state_t state;
  isa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      isa_pkg::S_IDLE: begin
        if (start) begin
          state_next = isa_pkg::S_DECODE;
        end
      end
      isa_pkg::S_DECODE: begin
        state_next = isa_pkg::S_IDLE;
        case (stat.func)
          isa_pkg::FUNC_INSERT: begin
            if (stat.in_range && !stat.full) begin
              state_next = isa_pkg::S_UP;
            end
          end
          isa_pkg::FUNC_REMOVE: begin
            if (stat.in_range && !stat.last_pos) begin
              state_next = isa_pkg::S_DOWN;
            end
          end
          isa_pkg::FUNC_READ: begin
            if (stat.in_range) begin
              state_next = isa_pkg::S_READ;
            end
          end
          default: begin
            state_next = isa_pkg::S_IDLE;
          end
        endcase
      end
      isa_pkg::S_READ: begin
        state_next = isa_pkg::S_IDLE;
      end
      isa_pkg::S_UP: begin
        if (stat.at_pos) begin
          state_next = isa_pkg::S_FIN;
        end
      end
      isa_pkg::S_FIN: begin
        state_next = isa_pkg::S_IDLE;
      end
      isa_pkg::S_DOWN: begin
        if (stat.at_last) begin
          state_next = isa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = isa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != isa_pkg::S_IDLE);
    case (state)
      isa_pkg::S_IDLE: begin
        cmd.latch = start;
      end
      isa_pkg::S_DECODE: begin
        case (stat.func)
          isa_pkg::FUNC_APPEND: begin
            cmd.finish = 1'b1;
            if (stat.full) begin
              cmd.fin_status = isa_pkg::STATUS_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = isa_pkg::WR_COUNT;
              cmd.wd_sel  = isa_pkg::WD_VALUE;
              cmd.cnt_inc = 1'b1;
            end
          end
          isa_pkg::FUNC_INSERT: begin
            if (!stat.in_range) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = isa_pkg::STATUS_RANGE;
            end else if (stat.full) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = isa_pkg::STATUS_FULL;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = isa_pkg::RD_LAST;
            end
          end
          isa_pkg::FUNC_REMOVE: begin
            if (!stat.in_range) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = isa_pkg::STATUS_RANGE;
            end else if (stat.last_pos) begin
              cmd.finish  = 1'b1;
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = isa_pkg::RD_POS_NEXT;
            end
          end
          isa_pkg::FUNC_READ: begin
            if (!stat.in_range) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = isa_pkg::STATUS_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = isa_pkg::RD_POS;
            end
          end
          isa_pkg::FUNC_WRITE: begin
            cmd.finish = 1'b1;
            if (!stat.in_range) begin
              cmd.fin_status = isa_pkg::STATUS_RANGE;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = isa_pkg::WR_POS;
              cmd.wd_sel = isa_pkg::WD_VALUE;
            end
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      isa_pkg::S_READ: begin
        cmd.finish    = 1'b1;
        cmd.fin_rdata = 1'b1;
      end
      isa_pkg::S_UP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = isa_pkg::WR_CUR_INC;
        cmd.wd_sel = isa_pkg::WD_RDATA;
        if (!stat.at_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = isa_pkg::RD_CUR_DEC;
        end
      end
      isa_pkg::S_FIN: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = isa_pkg::WR_POS;
        cmd.wd_sel  = isa_pkg::WD_VALUE;
        cmd.cnt_inc = 1'b1;
        cmd.finish  = 1'b1;
      end
      isa_pkg::S_DOWN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = isa_pkg::WR_CUR_DEC;
        cmd.wd_sel = isa_pkg::WD_RDATA;
        if (stat.at_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.finish  = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = isa_pkg::RD_CUR_INC;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/isa_dp.sv
// Datapath of the indexed shift array: request registers, live count,
// shift cursor, entry RAM and result registers. Depends on isa_pkg, isa_ram.
`default_nettype none

module isa_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire isa_pkg::dp_cmd_t              cmd,
  input  wire logic [isa_pkg::FUNC_W-1:0]    func,
  input  wire logic [isa_pkg::DATA_W-1:0]    value,
  input  wire logic [isa_pkg::POS_W-1:0]     position,
  output isa_pkg::dp_stat_t                  stat,
  output logic                               done,
  output logic [isa_pkg::DATA_W-1:0]         read_value,
  output logic [isa_pkg::STATUS_W-1:0]       status,
  output logic [isa_pkg::COUNT_W-1:0]        count
);

  logic [isa_pkg::FUNC_W-1:0] func_q;
  logic [isa_pkg::DATA_W-1:0] value_q;
  logic [isa_pkg::POS_W-1:0]  pos_q;
  logic [isa_pkg::CNT_W-1:0]  cnt;
  logic [isa_pkg::ADDR_W-1:0] cursor;
  logic [isa_pkg::ADDR_W-1:0] rd_addr;
  logic [isa_pkg::ADDR_W-1:0] wr_addr;
  logic [isa_pkg::DATA_W-1:0] wr_data;
  logic [isa_pkg::DATA_W-1:0] rd_data;
  logic [isa_pkg::ADDR_W-1:0] pos_addr;
  logic [isa_pkg::CMP_W-1:0]  pos_c;
  logic [isa_pkg::CMP_W-1:0]  cnt_c;
  logic [isa_pkg::CMP_W-1:0]  cur_c;

  assign pos_addr = isa_pkg::ADDR_W'(pos_q);
  assign pos_c    = isa_pkg::CMP_W'(pos_q);
  assign cnt_c    = isa_pkg::CMP_W'(cnt);
  assign cur_c    = isa_pkg::CMP_W'(cursor);

  assign stat.func     = func_q;
  assign stat.in_range = (pos_c < cnt_c);
  assign stat.full     = (cnt >= isa_pkg::CNT_W'(isa_pkg::DEPTH));
  assign stat.at_pos   = (cur_c == pos_c);
  assign stat.at_last  = ((cur_c + isa_pkg::CMP_W'(1)) == cnt_c);
  assign stat.last_pos = ((pos_c + isa_pkg::CMP_W'(1)) == cnt_c);

  always_comb begin
    case (cmd.rd_sel)
      isa_pkg::RD_POS:      rd_addr = pos_addr;
      isa_pkg::RD_LAST:     rd_addr = isa_pkg::ADDR_W'(cnt - isa_pkg::CNT_W'(1));
      isa_pkg::RD_POS_NEXT: rd_addr = pos_addr + isa_pkg::ADDR_W'(1);
      isa_pkg::RD_CUR_DEC:  rd_addr = cursor - isa_pkg::ADDR_W'(1);
      isa_pkg::RD_CUR_INC:  rd_addr = cursor + isa_pkg::ADDR_W'(1);
      default:              rd_addr = cursor;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      isa_pkg::WR_COUNT:   wr_addr = isa_pkg::ADDR_W'(cnt);
      isa_pkg::WR_POS:     wr_addr = pos_addr;
      isa_pkg::WR_CUR_INC: wr_addr = cursor + isa_pkg::ADDR_W'(1);
      isa_pkg::WR_CUR_DEC: wr_addr = cursor - isa_pkg::ADDR_W'(1);
      default:             wr_addr = pos_addr;
    endcase
  end

  assign wr_data = (cmd.wd_sel == isa_pkg::WD_RDATA) ? rd_data : value_q;

  isa_ram #(
    .WIDTH (isa_pkg::DATA_W),
    .DEPTH (isa_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q  <= func;
      value_q <= value;
      pos_q   <= position;
    end
    if (cmd.rd_en) begin
      cursor <= rd_addr;
    end
    if (cmd.finish) begin
      status     <= cmd.fin_status;
      read_value <= cmd.fin_rdata ? rd_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.cnt_inc) begin
        cnt <= cnt + isa_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - isa_pkg::CNT_W'(1);
      end
    end
  end

  assign count = isa_pkg::COUNT_W'(cnt);

endmodule

`default_nettype wire

### rtl/indexed_shift_array.sv
// Top level of the indexed shift array: joins the controller and the
// datapath. Depends on isa_pkg, isa_ctrl, isa_dp.
//
//   Channel   Direction  Handshake            Payload
//   request   in         start high, busy low func, value, position
//   result    out        done, one cycle      read_value, status, count
//
// One item is in work at a time; the next item can be taken in the cycle
// its predecessor's result is shown. Append, write, refused requests and
// removal of the last entry finish in the decode state, read in the read
// state after it. Insert moves entries from the last to the position up,
// then writes the value; other removals move the entries above the position
// down. One entry moves per cycle through the single write port of the RAM.
// Reset clears the live count; entry contents are unknown until written.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none

module indexed_shift_array (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [isa_pkg::FUNC_W-1:0]    func,
  input  wire logic signed [isa_pkg::DATA_W-1:0] value,
  input  wire logic [isa_pkg::POS_W-1:0]     position,
  output logic                               done,
  output logic signed [isa_pkg::DATA_W-1:0]  read_value,
  output logic [isa_pkg::STATUS_W-1:0]       status,
  output logic [isa_pkg::COUNT_W-1:0]        count
);

  isa_pkg::dp_cmd_t  cmd;
  isa_pkg::dp_stat_t stat;

  isa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  isa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (func),
    .value      (value),
    .position   (position),
    .stat       (stat),
    .done       (done),
    .read_value (read_value),
    .status     (status),
    .count      (count)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an item was accepted");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != isa_pkg::STATUS_OK)) |-> (read_value == '0))
    else $error("refused request returned a nonzero read value");

  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result shown in the cycle right after acceptance");

endmodule

`default_nettype wire

### bench/indexed_shift_array_tb.sv
// Self-checking testbench for indexed_shift_array: drives append, insert, remove,
// read and write requests and checks each result against a shadow copy of the array.
// Depends on isa_pkg and the indexed_shift_array RTL.
`timescale 1ns / 1ps

module indexed_shift_array_tb;

  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 80;

  localparam logic [isa_pkg::FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [isa_pkg::FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

  typedef enum int {
    MODE_FILL,
    MODE_MIXED,
    MODE_DRAIN
  } mode_t;

  typedef struct {
    logic [isa_pkg::FUNC_W-1:0]        func;
    logic signed [isa_pkg::DATA_W-1:0] value;
    logic [isa_pkg::POS_W-1:0]         position;
  } request_t;

  typedef struct {
    logic signed [isa_pkg::DATA_W-1:0] read_value;
    logic [isa_pkg::STATUS_W-1:0]      status;
    logic [isa_pkg::COUNT_W-1:0]       count;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [isa_pkg::FUNC_W-1:0] func = '0;
  logic signed [isa_pkg::DATA_W-1:0] value = '0;
  logic [isa_pkg::POS_W-1:0] position = '0;
  logic busy;
  logic done;
  logic signed [isa_pkg::DATA_W-1:0] read_value;
  logic [isa_pkg::STATUS_W-1:0] status;
  logic [isa_pkg::COUNT_W-1:0] count;

  logic took = 1'b0;
  logic no_idle = 1'b0;
  int idle_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  request_t requests_pending[$];
  reply_t replies_due[$];

  logic signed [isa_pkg::DATA_W-1:0] shadow_words[isa_pkg::DEPTH];
  int shadow_count = 0;

  indexed_shift_array dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .value(value),
    .position(position),
    .done(done),
    .read_value(read_value),
    .status(status),
    .count(count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic reply_t shadow_apply(logic [isa_pkg::FUNC_W-1:0] f,
                                          logic signed [isa_pkg::DATA_W-1:0] v,
                                          logic [isa_pkg::POS_W-1:0] p);
    reply_t r;
    logic in_range;
    logic full;
    int k;
    r.read_value = '0;
    r.status = isa_pkg::STATUS_OK;
    in_range = int'(p) < shadow_count;
    full = shadow_count >= isa_pkg::DEPTH;
    case (f)
      isa_pkg::FUNC_APPEND: begin
        if (full) begin
          r.status = isa_pkg::STATUS_FULL;
        end else begin
          shadow_words[shadow_count] = v;
          shadow_count++;
        end
      end
      isa_pkg::FUNC_INSERT: begin
        if (!in_range) begin
          r.status = isa_pkg::STATUS_RANGE;
        end else if (full) begin
          r.status = isa_pkg::STATUS_FULL;
        end else begin
          for (k = shadow_count; k > int'(p); k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[p] = v;
          shadow_count++;
        end
      end
      isa_pkg::FUNC_REMOVE: begin
        if (!in_range) begin
          r.status = isa_pkg::STATUS_RANGE;
        end else begin
          for (k = int'(p); k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k+1];
          shadow_count--;
        end
      end
      isa_pkg::FUNC_READ: begin
        if (!in_range) r.status = isa_pkg::STATUS_RANGE;
        else r.read_value = shadow_words[p];
      end
      isa_pkg::FUNC_WRITE: begin
        if (!in_range) r.status = isa_pkg::STATUS_RANGE;
        else shadow_words[p] = v;
      end
      default: begin
      end
    endcase
    r.count = isa_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [isa_pkg::DATA_W-1:0] got,
                                 logic [isa_pkg::DATA_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic add_request(logic [isa_pkg::FUNC_W-1:0] f,
                             logic signed [isa_pkg::DATA_W-1:0] v,
                             logic [isa_pkg::POS_W-1:0] p);
    request_t item;
    item.func = f;
    item.value = v;
    item.position = p;
    requests_pending.insert(requests_pending.size(), item);
  endtask

  always @(negedge clk) begin
    request_t item;
    int roll;
    if (!rst && !(start && !took)) begin
      if (took && start && !no_idle) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) idle_left = 0;
        else if (roll < 90) idle_left = $urandom_range(1, 3);
        else idle_left = $urandom_range(5, 40);
      end
      if (idle_left > 0) begin
        start <= 1'b0;
        idle_left--;
      end else if (requests_pending.size() > 0) begin
        item = requests_pending.pop_front();
        start <= 1'b1;
        func <= item.func;
        value <= item.value;
        position <= item.position;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    reply_t fresh;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (done) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with none expected, read_value", read_value, '0);
        end else begin
          want = replies_due.pop_front();
          if (read_value !== want.read_value)
            report_mismatch("read_value", read_value, want.read_value);
          if (status !== want.status)
            report_mismatch("status", isa_pkg::DATA_W'(status), isa_pkg::DATA_W'(want.status));
          if (count !== want.count)
            report_mismatch("count", isa_pkg::DATA_W'(count), isa_pkg::DATA_W'(want.count));
        end
      end
      if (start && !busy) begin
        fresh = shadow_apply(func, value, position);
        replies_due.insert(replies_due.size(), fresh);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    mode_t mode;
    int phase_left;
    int n_real;
    int roll;
    int live;
    int t_app, t_ins, t_rem, t_rd, t_wr;
    int f_code;
    logic [isa_pkg::FUNC_W-1:0] f;
    logic signed [isa_pkg::DATA_W-1:0] v;
    logic [isa_pkg::POS_W-1:0] p;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Requests on the empty array are all out of range.
    add_request(isa_pkg::FUNC_READ, 32'sd5, 6'd0);
    add_request(isa_pkg::FUNC_REMOVE, 32'sd5, 6'd0);
    add_request(isa_pkg::FUNC_WRITE, 32'sd5, 6'd0);
    add_request(isa_pkg::FUNC_INSERT, 32'sd5, 6'd0);
    add_request(isa_pkg::FUNC_APPEND, 32'h8000_0000, 6'd0);
    add_request(isa_pkg::FUNC_APPEND, 32'h7fff_ffff, 6'd63);
    add_request(isa_pkg::FUNC_APPEND, 32'sd0, 6'd0);
    add_request(isa_pkg::FUNC_INSERT, -32'sd1, 6'd0);
    add_request(isa_pkg::FUNC_INSERT, 32'h5555_5555, 6'd1);
    // Inserting at the count itself is refused even though space remains.
    add_request(isa_pkg::FUNC_INSERT, 32'sd7, 6'd5);
    for (int i = 0; i < 5; i++) add_request(isa_pkg::FUNC_READ, 32'sd0, isa_pkg::POS_W'(i));
    add_request(isa_pkg::FUNC_WRITE, 32'haaaa_aaaa, 6'd4);
    add_request(isa_pkg::FUNC_READ, 32'sd0, 6'd4);
    add_request(isa_pkg::FUNC_REMOVE, 32'sd0, 6'd0);
    add_request(isa_pkg::FUNC_REMOVE, 32'sd0, 6'd3);
    add_request(isa_pkg::FUNC_READ, 32'sd0, 6'd63);
    for (int i = FUNC_UNUSED_FIRST; i <= FUNC_UNUSED_LAST; i++)
      add_request(isa_pkg::FUNC_W'(i), -32'sd1, 6'd63);

    n_real = 0;
    phase_left = 0;
    mode = MODE_FILL;
    while (n_real < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        mode = mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 150);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      while (requests_pending.size() >= 2) @(posedge clk);

      case (mode)
        MODE_FILL: begin
          t_app = 55; t_ins = 80; t_rem = 85; t_rd = 93; t_wr = 98;
        end
        MODE_DRAIN: begin
          t_app = 10; t_ins = 20; t_rem = 60; t_rd = 80; t_wr = 95;
        end
        default: begin
          t_app = 25; t_ins = 45; t_rem = 65; t_rd = 80; t_wr = 97;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < t_app) f = isa_pkg::FUNC_APPEND;
      else if (roll < t_ins) f = isa_pkg::FUNC_INSERT;
      else if (roll < t_rem) f = isa_pkg::FUNC_REMOVE;
      else if (roll < t_rd) f = isa_pkg::FUNC_READ;
      else if (roll < t_wr) f = isa_pkg::FUNC_WRITE;
      else begin
        f_code = $urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST);
        f = isa_pkg::FUNC_W'(f_code);
      end

      v = $urandom;
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end

      live = shadow_count;
      roll = $urandom_range(0, 99);
      if (live > 0 && roll < 80) p = isa_pkg::POS_W'($urandom_range(0, live - 1));
      else if (roll < 90) p = (live > 63) ? 6'd63 : isa_pkg::POS_W'(live);
      else p = isa_pkg::POS_W'($urandom_range(0, 63));

      add_request(f, v, p);
      if (f <= isa_pkg::FUNC_WRITE) n_real++;
      phase_left--;
    end

    while (requests_pending.size() != 0 || start || replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### indexed_shift_array.f
rtl/isa_pkg.sv
rtl/isa_ram.sv
rtl/isa_ctrl.sv
rtl/isa_dp.sv
rtl/indexed_shift_array.sv
bench/indexed_shift_array_tb.sv
